// ===== hw/rtl/coverage_srcover_blend_core_defines.svh =====
// Assertion macros shared by the coverage source-over blend RTL.
`ifndef COVERAGE_SRCOVER_BLEND_CORE_DEFINES_SVH
`define COVERAGE_SRCOVER_BLEND_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSB_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/csb_pkg.sv =====
// Types, constants and unorm helpers for the coverage source-over blend.
`default_nettype none

package csb_pkg;

	localparam int unsigned ChanW  = 8;
	localparam int unsigned ProdW  = 2 * ChanW;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [ChanW-1:0] UnormMax = {ChanW{1'b1}};

	// register indexes of the config port
	typedef enum logic [CfgIdxW-1:0] {
		CFG_SRC_RED   = 3'd0,
		CFG_SRC_GREEN = 3'd1,
		CFG_SRC_BLUE  = 3'd2,
		CFG_SRC_ALPHA = 3'd3,
		CFG_COV_EN    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] alpha;
	} rgba_t;

	typedef struct packed {
		logic [ProdW-1:0] red;
		logic [ProdW-1:0] green;
		logic [ProdW-1:0] blue;
		logic [ProdW-1:0] alpha;
	} prod_t;

	// scale stage -> blend stage
	typedef struct packed {
		logic             valid;
		logic             last;
		rgba_t            src;
		rgba_t            dst;
		logic [ChanW-1:0] inv;
	} scaled_t;

	// round(p / 255) for p <= 255*255, equal to floor((p + 127) / 255)
	function automatic logic [ChanW-1:0] mul255(input logic [ProdW-1:0] p);
		logic [ProdW:0] t;
		logic [ProdW:0] u;
		begin
			t = {1'b0, p} + (ProdW+1)'(128);
			u = t + (ProdW+1)'(t >> ChanW);
			mul255 = u[ChanW +: ChanW];
		end
	endfunction

	function automatic logic [ChanW-1:0] sat_add(input logic [ChanW-1:0] a,
		input logic [ChanW-1:0] b);
		logic [ChanW:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			sat_add = s[ChanW] ? UnormMax : s[ChanW-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csb_scale.sv =====
// Stages 1-2: scale the solid source color by coverage, form 255 - alpha.
`default_nettype none

module csb_scale import csb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire rgba_t            in_dst,
	input  wire logic [ChanW-1:0] in_cov,
	input  wire logic             in_last,
	input  wire rgba_t            cfg_src,
	input  wire logic             cfg_cov_en,
	output scaled_t               scaled
);

	logic             valid_s1;
	logic             last_s1;
	rgba_t            dst_s1;
	prod_t            prod_s1;
	logic             valid_s2;
	logic             last_s2;
	rgba_t            dst_s2;
	rgba_t            src_s2;
	logic [ChanW-1:0] inv_s2;
	logic [ChanW-1:0] cov;
	rgba_t            src_scaled;

	assign cov = cfg_cov_en ? in_cov : UnormMax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: four 8x8 products
	always_ff @(posedge clk) begin
		last_s1       <= in_last;
		dst_s1        <= in_dst;
		prod_s1.red   <= ProdW'(cfg_src.red)   * ProdW'(cov);
		prod_s1.green <= ProdW'(cfg_src.green) * ProdW'(cov);
		prod_s1.blue  <= ProdW'(cfg_src.blue)  * ProdW'(cov);
		prod_s1.alpha <= ProdW'(cfg_src.alpha) * ProdW'(cov);
	end

	always_comb begin
		src_scaled.red   = mul255(prod_s1.red);
		src_scaled.green = mul255(prod_s1.green);
		src_scaled.blue  = mul255(prod_s1.blue);
		src_scaled.alpha = mul255(prod_s1.alpha);
	end

	// stage 2: back to unorm
	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		dst_s2  <= dst_s1;
		src_s2  <= src_scaled;
		inv_s2  <= UnormMax - src_scaled.alpha;
	end

	assign scaled.valid = valid_s2;
	assign scaled.last  = last_s2;
	assign scaled.src   = src_s2;
	assign scaled.dst   = dst_s2;
	assign scaled.inv   = inv_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/csb_blend.sv =====
// Stages 3-4: dst * (255 - alpha), add scaled source, saturate.
`default_nettype none

module csb_blend import csb_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire scaled_t scaled,
	output logic         out_valid,
	output logic         out_last,
	output rgba_t        out_pix
);

	logic  valid_s3;
	logic  last_s3;
	rgba_t src_s3;
	prod_t prod_s3;
	logic  valid_s4;
	logic  last_s4;
	rgba_t pix_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= scaled.valid;
			valid_s4 <= valid_s3;
		end
	end

	// stage 3: destination products
	always_ff @(posedge clk) begin
		last_s3       <= scaled.last;
		src_s3        <= scaled.src;
		prod_s3.red   <= ProdW'(scaled.dst.red)   * ProdW'(scaled.inv);
		prod_s3.green <= ProdW'(scaled.dst.green) * ProdW'(scaled.inv);
		prod_s3.blue  <= ProdW'(scaled.dst.blue)  * ProdW'(scaled.inv);
		prod_s3.alpha <= ProdW'(scaled.dst.alpha) * ProdW'(scaled.inv);
	end

	// stage 4: round, add, clamp
	always_ff @(posedge clk) begin
		last_s4      <= last_s3;
		pix_s4.red   <= sat_add(src_s3.red,   mul255(prod_s3.red));
		pix_s4.green <= sat_add(src_s3.green, mul255(prod_s3.green));
		pix_s4.blue  <= sat_add(src_s3.blue,  mul255(prod_s3.blue));
		pix_s4.alpha <= sat_add(src_s3.alpha, mul255(prod_s3.alpha));
	end

	assign out_valid = valid_s4;
	assign out_last  = last_s4;
	assign out_pix   = pix_s4;

endmodule

`default_nettype wire

// ===== hw/rtl/coverage_srcover_blend_core.sv =====
// Top level of the coverage-scaled solid-color source-over blend pipeline.
`default_nettype none

// Solid-color source-over blend, RGBA8 in, RGBA8 out. An item (one
// destination pixel, its coverage and the last-pixel mark) is taken at every
// clock edge where start is high; busy is always low, so the block sustains
// one item per cycle. Each item yields exactly one result from stage s4:
// done is high for one cycle and out_red..out_alpha/out_last hold the result
// during that cycle only. There is no backpressure - the receiver must take
// every result as it appears. The result passes four pipeline stages:
//   s1  source * coverage (four 8x8 multipliers)
//   s2  divide by 255 with rounding, alpha inverse
//   s3  destination * (255 - scaled alpha)
//   s4  divide by 255, add scaled source, clamp to 255
// Products are rounded to nearest: round(p/255). The source color is not
// premultiplied, so a color channel can exceed alpha and saturate.
// Config registers (index: name): 0 red, 1 green, 2 blue, 3 alpha, 4 coverage
// enable. Write only while the pipe is empty; writes to other indexes are
// dropped. With coverage enable low the coverage input is treated as 255.

`include "coverage_srcover_blend_core_defines.svh"

module coverage_srcover_blend_core import csb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// config write port
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [ChanW-1:0]   cfg_data,
	// item in
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [ChanW-1:0]   dest_red,
	input  wire logic [ChanW-1:0]   dest_green,
	input  wire logic [ChanW-1:0]   dest_blue,
	input  wire logic [ChanW-1:0]   dest_alpha,
	input  wire logic [ChanW-1:0]   coverage,
	input  wire logic               last_pixel,
	// result out
	output logic                    done,
	output logic [ChanW-1:0]        out_red,
	output logic [ChanW-1:0]        out_green,
	output logic [ChanW-1:0]        out_blue,
	output logic [ChanW-1:0]        out_alpha,
	output logic                    out_last
);

	rgba_t   src_color_q;
	logic    cov_en_q;
	logic    accept;
	rgba_t   dst;
	rgba_t   pix;
	scaled_t scaled;

	// fully pipelined, never stalls
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_color_q.red   <= ChanW'(0);
			src_color_q.green <= ChanW'(128);
			src_color_q.blue  <= ChanW'(0);
			src_color_q.alpha <= ChanW'(128);
			cov_en_q          <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SRC_RED:   src_color_q.red   <= cfg_data;
				CFG_SRC_GREEN: src_color_q.green <= cfg_data;
				CFG_SRC_BLUE:  src_color_q.blue  <= cfg_data;
				CFG_SRC_ALPHA: src_color_q.alpha <= cfg_data;
				CFG_COV_EN:    cov_en_q          <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	assign dst.red   = dest_red;
	assign dst.green = dest_green;
	assign dst.blue  = dest_blue;
	assign dst.alpha = dest_alpha;

	csb_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.in_dst     (dst),
		.in_cov     (coverage),
		.in_last    (last_pixel),
		.cfg_src    (src_color_q),
		.cfg_cov_en (cov_en_q),
		.scaled     (scaled)
	);

	csb_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.scaled    (scaled),
		.out_valid (done),
		.out_last  (out_last),
		.out_pix   (pix)
	);

	assign out_red   = pix.red;
	assign out_green = pix.green;
	assign out_blue  = pix.blue;
	assign out_alpha = pix.alpha;

	// every accepted item comes out of stage s4 with done high
	`CSB_ASSERT(a_latency, clk, arst_n, accept, ##4 done, "item result missing")
	// last mark travels with its item
	`CSB_ASSERT(a_last_kept, clk, arst_n, accept, ##4 (out_last == $past(last_pixel, 4)), "last mark lost")
	// zero coverage leaves the destination untouched
	`CSB_ASSERT(a_zero_cov, clk, arst_n, accept && cov_en_q && (coverage == '0), ##4 ((out_red == $past(dest_red, 4)) && (out_alpha == $past(dest_alpha, 4))), "zero coverage changed pixel")
	// idle input gives an idle output slot in the pipe
	`CSB_ASSERT_NEXT(a_s1_idle, clk, arst_n, !accept, ##3 (done == 1'b0), "result without item")

endmodule

`default_nettype wire
